FILE: rtl/core/strmq_pkg.sv
// Package for the sparse table range minimum query unit.
// Holds word types, opcodes, status codes and controller command structs.
// No dependencies.
package strmq_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_RANGE = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;
  localparam logic [1:0] ST_BAD_COUNT = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         position;
    logic signed [31:0] value;
    logic [10:0]        count;
    logic [9:0]         query_low;
    logic [9:0]         query_high;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         min_index;
    logic signed [31:0] min_value;
    logic [1:0]         status;
  } out_word_t;

  // Datapath sequencing commands issued by the controller.
  typedef struct packed {
    logic load;       // capture the input word and do checks
    logic wr_elem;    // write element store
    logic b_init;     // start of build
    logic b_lvl0;     // level 0 copy step
    logic b_rd;       // issue level k-1 table reads
    logic b_el;       // issue element reads
    logic b_wr;       // compare and write level k
    logic q_rd;       // issue query table reads
    logic q_el;       // issue query element reads
    logic q_cmp;      // compare and capture result
    logic done;       // emit result
  } cmd_t;

  typedef struct packed {
    logic lvl0_last;
    logic row_last;
    logic levels_done;
  } stat_t;

endpackage

FILE: rtl/core/strmq_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module strmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/strmq_ctrl.sv
// Controller state machine for the range minimum unit.
// Depends on strmq_pkg.
module strmq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  logic              go_build,
  input  logic              go_query,
  input  strmq_pkg::stat_t  stat,
  output logic              busy,
  output strmq_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CHECK = 12'b000000000010,
    S_LVL0  = 12'b000000000100,
    S_BRD   = 12'b000000001000,
    S_BEL   = 12'b000000010000,
    S_BWR   = 12'b000000100000,
    S_QRD   = 12'b000001000000,
    S_QEL   = 12'b000010000000,
    S_QCMP  = 12'b000100000000,
    S_DONE  = 12'b001000000000,
    S_WAIT  = 12'b010000000000,
    S_BEL2  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (go_build) begin
          cmd.b_init = 1'b1;
          state_next = S_LVL0;
        end else if (go_query) begin
          cmd.q_rd = 1'b1;
          state_next = S_QRD;
        end else begin
          cmd.wr_elem = (opcode == strmq_pkg::OP_WRITE);
          state_next = S_DONE;
        end
      end
      S_LVL0: begin
        cmd.b_lvl0 = 1'b1;
        if (stat.lvl0_last) begin
          state_next = stat.levels_done ? S_DONE : S_BRD;
        end
      end
      S_BRD: begin
        cmd.b_rd = 1'b1;
        state_next = S_BEL;
      end
      S_BEL: begin
        cmd.b_el = 1'b1;
        state_next = S_BEL2;
      end
      S_BEL2: begin
        cmd.b_el = 1'b1;
        state_next = S_BWR;
      end
      S_BWR: begin
        cmd.b_wr = 1'b1;
        if (stat.row_last && stat.levels_done) begin
          state_next = S_DONE;
        end else begin
          state_next = S_BRD;
        end
      end
      S_QRD: begin
        cmd.q_el = 1'b1;
        state_next = S_QEL;
      end
      S_QEL: state_next = S_QCMP;
      S_QCMP: begin
        cmd.q_cmp = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start not taken");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> !cmd.done)
    else $error("double result");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state not one-hot");

endmodule

FILE: rtl/core/strmq_dp.sv
// Datapath: element store, sparse table memory, build counters, query logic.
// Depends on strmq_pkg and strmq_ram.
module strmq_dp #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int TABLE_LEVELS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  strmq_pkg::in_word_t  in_word,
  input  strmq_pkg::cmd_t      cmd,
  output logic                 go_build,
  output logic                 go_query,
  output strmq_pkg::stat_t     stat,
  output strmq_pkg::out_word_t result
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int LW = $clog2(TABLE_LEVELS);
  localparam int TD = TABLE_LEVELS * MAX_ELEMENTS;
  localparam int TW = $clog2(TD);

  strmq_pkg::in_word_t req;
  logic [10:0] element_count;
  logic        table_built;
  logic [1:0]  status;
  logic [9:0]  res_idx;
  logic signed [31:0] res_val;

  logic          e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [31:0]   e_wdata, e_rdata;
  logic          t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [9:0]    t_wdata, t_rdata;

  strmq_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));
  strmq_ram #(.WIDTH(10), .DEPTH(TD)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata));

  // Build counters: level k, row i, and captured left/right candidates.
  logic [LW-1:0] lvl;
  logic [16:0]   row;
  logic [9:0]    cand_l, cand_r;
  logic signed [31:0] val_l;
  logic [1:0]    phase;

  logic [16:0] n;
  logic [16:0] span, half;
  logic        qlen_bad;
  logic [4:0]  qlen;
  logic [10:0] qdiff;
  logic [10:0] qstart_r;

  assign n    = 17'(element_count);
  assign span = 17'(1) << lvl;
  assign half = 17'(1) << (lvl - LW'(1));

  always_comb begin
    qlen = '0;
    for (int b = 0; b < 11; b++) begin
      if (qdiff[b]) qlen = 5'(b);
    end
  end
  assign qdiff    = 11'(req.query_high) - 11'(req.query_low) + 11'd1;
  assign qlen_bad = (32'(qlen) >= TABLE_LEVELS);
  assign qstart_r = 11'(req.query_high) + 11'd1 - (11'd1 << qlen);

  logic next_lvl_fits;
  assign next_lvl_fits = (32'(lvl) + 1 < TABLE_LEVELS) && ((17'(2) << lvl) <= n);
  assign stat.lvl0_last   = (row + 17'd1 >= n);
  assign stat.row_last    = (row + span + 17'd1 > n);
  assign stat.levels_done = stat.lvl0_last && cmd.b_lvl0 ? !((17'd2 <= n) && TABLE_LEVELS > 1)
                                                        : !next_lvl_fits;

  always_comb begin
    go_build = (req.opcode == strmq_pkg::OP_BUILD) && (status == strmq_pkg::ST_OK);
    go_query = (req.opcode == strmq_pkg::OP_QUERY) && (status == strmq_pkg::ST_OK);
  end

  always_comb begin
    e_we = cmd.wr_elem && (status == strmq_pkg::ST_OK);
    e_waddr = AW'(req.position);
    e_wdata = req.value;
    e_raddr = AW'(cand_l);
    t_we = 1'b0;
    t_waddr = TW'(32'(lvl) * MAX_ELEMENTS + 32'(row));
    t_wdata = 10'(row);
    t_raddr = '0;
    if (cmd.b_lvl0) begin
      t_we = 1'b1;
    end
    if (cmd.b_rd || phase == 2'd1) begin
      t_raddr = (phase == 2'd0)
        ? TW'((32'(lvl) - 1) * MAX_ELEMENTS + 32'(row))
        : TW'((32'(lvl) - 1) * MAX_ELEMENTS + 32'(row) + 32'(half));
    end
    if (cmd.q_rd || cmd.q_el) begin
      t_raddr = cmd.q_rd ? TW'(32'(qlen) * MAX_ELEMENTS + 32'(req.query_low))
                         : TW'(32'(qlen) * MAX_ELEMENTS + 32'(qstart_r));
    end
    if (cmd.b_wr) begin
      t_we = 1'b1;
      t_wdata = ($signed(val_l) <= $signed(e_rdata)) ? cand_l : cand_r;
    end
    if (phase == 2'd1) e_raddr = AW'(t_rdata);
    if (phase == 2'd2) e_raddr = AW'(t_rdata);
  end

  // The build step is a left table read, a right table read with the left element
  // read, a right element read, then the compare. Phase tracks the reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      table_built <= 1'b0;
      phase <= '0;
      req <= '0;
    end else begin
      phase <= '0;
      if (cmd.load) begin
        req <= in_word;
      end
      if (e_we) table_built <= 1'b0;
      if (cmd.b_init) begin
        element_count <= req.count;
        table_built <= 1'b1;
        lvl <= '0;
        row <= '0;
      end
      if (cmd.b_lvl0) begin
        if (stat.lvl0_last) begin
          lvl <= LW'(1);
          row <= '0;
        end else begin
          row <= row + 17'd1;
        end
      end
      if (cmd.b_rd || cmd.q_rd) phase <= 2'd1;
      if (phase == 2'd1) begin
        cand_l <= t_rdata;
        phase <= 2'd2;
      end
      if (phase == 2'd2) begin
        cand_r <= t_rdata;
        val_l <= e_rdata;
        phase <= 2'd3;
      end
      if (cmd.b_wr) begin
        if (stat.row_last) begin
          lvl <= lvl + LW'(1);
          row <= '0;
        end else begin
          row <= row + 17'd1;
        end
      end
    end
  end

  // Status set the cycle after load, rechecked at query read; result at compare.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_idx <= '0;
      res_val <= '0;
      status <= strmq_pkg::ST_OK;
      case (in_word.opcode)
        strmq_pkg::OP_WRITE:
          if (32'(in_word.position) >= MAX_ELEMENTS) status <= strmq_pkg::ST_BAD_RANGE;
        strmq_pkg::OP_BUILD:
          if (in_word.count == 11'd0 || 32'(in_word.count) > MAX_ELEMENTS)
            status <= strmq_pkg::ST_BAD_COUNT;
        strmq_pkg::OP_QUERY:
          if (!table_built) status <= strmq_pkg::ST_NOT_BUILT;
          else if (in_word.query_low > in_word.query_high ||
                   11'(in_word.query_high) >= element_count)
            status <= strmq_pkg::ST_BAD_RANGE;
        default: status <= strmq_pkg::ST_OK;
      endcase
    end else if (cmd.q_rd && qlen_bad) begin
      status <= strmq_pkg::ST_BAD_RANGE;
    end else if (cmd.q_cmp && status == strmq_pkg::ST_OK) begin
      if ($signed(val_l) <= $signed(e_rdata)) begin
        res_idx <= cand_l;
        res_val <= val_l;
      end else begin
        res_idx <= cand_r;
        res_val <= e_rdata;
      end
    end
  end

  assign result.min_index = res_idx;
  assign result.min_value = res_val;
  assign result.status    = status;

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.b_wr |-> (row + span <= n))
    else $error("build row past count");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(go_build && go_query))
    else $error("build and query both");
  a_cmp_phase: assert property (@(posedge clk) disable iff (rst)
    (cmd.q_cmp || cmd.b_wr) |-> (phase == 2'd3))
    else $error("compare before both element reads");

endmodule

FILE: rtl/core/sparse_table_range_min_query_unit.sv
// Top level of the sparse table range minimum query unit.
// Depends on strmq_pkg, strmq_ctrl, strmq_dp.
//
//   channel  | handshake     | word
//   input    | start / busy  | in_word  (strmq_pkg::in_word_t)
//   result   | done strobe   | result   (strmq_pkg::out_word_t)
//
// A write or a rejected item passes from accept through check to done and a wait
// state before the next accept; a query adds its table reads, element reads and compare.
// A build writes level 0 one entry at a time, then for each higher-level entry reads
// the left table entry, the right one with the left element, then the right element,
// and compares; the single table read port and the dependent element reads set this.
// Reset clears the count and built flag; both RAMs hold garbage until written.
// done is high for one cycle; the receiver cannot stall it.
module sparse_table_range_min_query_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int TABLE_LEVELS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  strmq_pkg::in_word_t  in_word,
  output logic                 done,
  output strmq_pkg::out_word_t result
);

  strmq_pkg::cmd_t  cmd;
  strmq_pkg::stat_t stat;
  logic go_build, go_query;
  logic [1:0] in_word_q_op;

  strmq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(in_word_q_op),
    .go_build(go_build), .go_query(go_query), .stat(stat),
    .busy(busy), .cmd(cmd));

  always_ff @(posedge clk) begin
    if (start && !busy) in_word_q_op <= in_word.opcode;
  end

  strmq_dp #(.MAX_ELEMENTS(MAX_ELEMENTS), .TABLE_LEVELS(TABLE_LEVELS)) u_dp (
    .clk(clk), .rst(rst), .in_word(in_word), .cmd(cmd),
    .go_build(go_build), .go_query(go_query), .stat(stat), .result(result));

  assign done = cmd.done;

endmodule
